// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the circular LBP RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/clbp_pkg.sv =====
// Shared types and constants of the circular LBP code core.
// Depends on nothing; imported by the core, scan and sampler modules.
package clbp_pkg;

	localparam int CFG_DATA_BITS  = 16;
	localparam int WIDTH_REG_BITS = 11;
	localparam int HEIGHT_BITS    = 16;
	localparam int IN_PIX_BITS    = 8;
	localparam int CODE_BITS      = 8;

	localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0]    HEIGHT_RESET = 16'd480;

	// Angle pi/2 in Q30.
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	localparam int TAP_IDX_BITS = 5;
	localparam int WEIGHT_BITS  = 17;

	typedef enum logic [0:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Per-beat control that travels along the pipeline.
	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} beat_ctrl_t;

	// One sample point: window indexes of the four corners and their weights.
	typedef struct packed {
		logic [TAP_IDX_BITS-1:0] row_lo;
		logic [TAP_IDX_BITS-1:0] row_hi;
		logic [TAP_IDX_BITS-1:0] col_lo;
		logic [TAP_IDX_BITS-1:0] col_hi;
		logic [3:0][WEIGHT_BITS-1:0] wt;
	} tap_t;

endpackage

// ===== hdl/circular_lbp_code_core.sv =====
// Circular LBP code core: one pixel beat accepted per clock while the output is not stalled.
// A code reaches the output register after the pixel beat that completes its window
// passes the line-store read, window shift, weight products and compare.
// Throughput: 1 pixel per cycle while not stalled, limited by the single line-store read port.
// Reset clears counters, window and pipeline valids; line store is not cleared.
// Depends on clbp_pkg, clbp_ram, clbp_scan, clbp_sampler, assert_macros.svh.
`include "assert_macros.svh"

module circular_lbp_code_core #(
	parameter int RADIUS     = 1,
	parameter int NEIGHBORS  = 8,
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// pixel channel
	input  logic                                 pixel_valid,
	output logic                                 pixel_stall,
	input  logic [clbp_pkg::IN_PIX_BITS-1:0]     pixel,
	input  logic                                 frame_start,
	// code channel
	output logic                                 code_valid,
	input  logic                                 code_stall,
	output logic [clbp_pkg::CODE_BITS-1:0]       pattern_code,
	output logic                                 row_end,
	output logic                                 frame_end,
	// configuration writes
	input  logic                                 cfg_we,
	input  clbp_pkg::cfg_reg_t                   cfg_index,
	input  logic [clbp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	import clbp_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int PB   = PIXEL_BITS;
	localparam int LW   = 2 * RADIUS * PB;          // one line-store word: 2R rows
	localparam int CB   = (NEIGHBORS > CODE_BITS) ? NEIGHBORS : CODE_BITS;

	// Whole pipeline moves together; it holds only when a finished code is
	// stalled in the output register.
	logic advance;
	logic accept;

	logic [AW-1:0]  col;
	beat_ctrl_t     ctrl;

	// Stage 1: pixel beat waiting for its line-store read.
	logic           valid_s1;
	logic [PB-1:0]  pix_s1;
	logic [AW-1:0]  col_s1;
	beat_ctrl_t     ctrl_s1;
	logic           fwd_s1;
	logic [LW-1:0]  fwd_data_s1;

	logic [LW-1:0]  rd_data;
	logic [LW-1:0]  line_s1;
	logic [LW-1:0]  wr_data;
	logic           ram_we;

	logic           valid_s3;
	beat_ctrl_t     ctrl_s3;
	logic [NEIGHBORS-1:0] code_n;
	logic [CB-1:0]  code_ext;

	logic                  code_valid_q;
	logic [CODE_BITS-1:0]  pattern_code_q;
	logic                  row_end_q;
	logic                  frame_end_q;

	assign advance     = !(code_valid_q && code_stall);
	assign pixel_stall = !advance;
	assign accept      = pixel_valid && advance;

	clbp_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.RADIUS    (RADIUS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (frame_start),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.col         (col),
		.ctrl        (ctrl)
	);

	// Line store: one word per column, oldest row in the low slot. Read at
	// accept, write back the shifted word when stage 1 advances.
	clbp_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (col),
		.rdata (rd_data)
	);

	// Forward the word being written when the next beat reads the same column
	// (very narrow frames); otherwise take the RAM output.
	assign line_s1 = fwd_s1 ? fwd_data_s1 : rd_data;
	// Drop the oldest row, push the new pixel on top.
	assign wr_data = {pix_s1, line_s1[LW-1:PB]};
	assign ram_we  = advance && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= PB'(pixel);
			col_s1      <= col;
			ctrl_s1     <= ctrl;
			fwd_s1      <= valid_s1 && (col_s1 == col);
			fwd_data_s1 <= wr_data;
		end
	end

	clbp_sampler #(
		.RADIUS     (RADIUS),
		.NEIGHBORS  (NEIGHBORS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_sampler (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.ctrl_s1  (ctrl_s1),
		.column   ({pix_s1, line_s1}),
		.valid_s3 (valid_s3),
		.ctrl_s3  (ctrl_s3),
		.code     (code_n)
	);

	// Only the low byte of a wide code leaves the block.
	assign code_ext = CB'(code_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_q <= 1'b0;
		end else if (advance) begin
			code_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pattern_code_q <= code_ext[CODE_BITS-1:0];
			row_end_q      <= ctrl_s3.row_end;
			frame_end_q    <= ctrl_s3.frame_end;
		end
	end

	assign code_valid   = code_valid_q;
	assign pattern_code = pattern_code_q;
	assign row_end      = row_end_q;
	assign frame_end    = frame_end_q;

	`ASSERT_IMPLIES(a_no_stall_when_empty, clk, arst_n, !code_valid, !pixel_stall, "pixel beat stalled while output register is empty")
	`ASSERT_IMPLIES(a_frame_end_on_row_end, clk, arst_n, code_valid && frame_end, row_end, "frame end flagged on a code that is not a row end")

endmodule

// ===== hdl/clbp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module clbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/clbp_scan.sv =====
// Raster position tracking and configuration registers of the LBP core.
// Depends on clbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clbp_scan #(
	parameter int MAX_WIDTH = 1024,
	parameter int RADIUS    = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  logic                                   frame_start,
	input  logic                                   cfg_we,
	input  clbp_pkg::cfg_reg_t                     cfg_index,
	input  logic [clbp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	output logic [$clog2(MAX_WIDTH)-1:0]           col,
	output clbp_pkg::beat_ctrl_t                   ctrl
);

	import clbp_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = (AW + 1 > WIDTH_REG_BITS) ? AW + 1 : WIDTH_REG_BITS;

	logic [WIDTH_REG_BITS-1:0] width_q;
	logic [HEIGHT_BITS-1:0]    height_q;
	logic [AW-1:0]             col_q;
	logic [HEIGHT_BITS-1:0]    row_q;

	logic [WW-1:0]            width_eff;
	logic [HEIGHT_BITS-1:0]   height_eff;
	logic [AW-1:0]            col_cur;
	logic [HEIGHT_BITS-1:0]   row_cur;
	logic [WW-1:0]            col_nxt;
	logic [HEIGHT_BITS:0]     row_nxt;
	logic                     row_last;
	logic                     frame_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_eff = WW'(width_q);
		if (width_eff == '0) begin
			width_eff = WW'(1);
		end else if (width_eff > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end
		height_eff = (height_q == '0) ? HEIGHT_BITS'(1) : height_q;

		col_cur    = frame_start ? '0 : col_q;
		row_cur    = frame_start ? '0 : row_q;
		col_nxt    = WW'(col_cur) + WW'(1);
		row_nxt    = {1'b0, row_cur} + (HEIGHT_BITS + 1)'(1);
		row_last   = col_nxt >= width_eff;
		frame_last = row_nxt >= {1'b0, height_eff};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_last) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : row_nxt[HEIGHT_BITS-1:0];
			end else begin
				col_q <= col_nxt[AW-1:0];
				row_q <= row_cur;
			end
		end
	end

	assign col            = col_cur;
	assign ctrl.emit      = (row_cur >= HEIGHT_BITS'(2 * RADIUS))
	                      && (WW'(col_cur) >= WW'(2 * RADIUS));
	assign ctrl.row_end   = row_last;
	assign ctrl.frame_end = row_last && frame_last;

	`ASSERT_NEXT(a_frame_wrap, clk, arst_n, accept && ctrl.frame_end, (col_q == '0) && (row_q == '0), "counters did not wrap after the last pixel of a frame")

endmodule

// ===== hdl/clbp_sampler.sv =====
// Neighborhood window, bilinear sample lanes and centre compare.
// Depends on clbp_pkg.
module clbp_sampler #(
	parameter int RADIUS     = 1,
	parameter int NEIGHBORS  = 8,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     advance,
	input  logic                                     valid_s1,
	input  clbp_pkg::beat_ctrl_t                     ctrl_s1,
	input  logic [(2*RADIUS+1)*PIXEL_BITS-1:0]       column,
	output logic                                     valid_s3,
	output clbp_pkg::beat_ctrl_t                     ctrl_s3,
	output logic [NEIGHBORS-1:0]                     code
);

	import clbp_pkg::*;

	localparam int SPAN = 2 * RADIUS + 1;
	localparam int PB   = PIXEL_BITS;
	localparam int PW   = PB + WEIGHT_BITS;

	// Sine or cosine in Q30 by Taylor series, theta in [0, pi/2).
	function automatic longint trig_q30(input longint unsigned theta, input bit want_sin);
		longint unsigned th2;
		longint unsigned term;
		longint unsigned prod;
		longint          sum;
		th2  = (theta * theta) >> 30;
		term = want_sin ? theta : (64'd1 << 30);
		sum  = longint'(term);
		for (int k = 1; k <= 8; k++) begin
			prod = (term * th2) >> 30;
			case (k)
				1: term = want_sin ? prod / 6   : prod / 2;
				2: term = want_sin ? prod / 20  : prod / 12;
				3: term = want_sin ? prod / 42  : prod / 30;
				4: term = want_sin ? prod / 72  : prod / 56;
				5: term = want_sin ? prod / 110 : prod / 90;
				6: term = want_sin ? prod / 156 : prod / 132;
				7: term = want_sin ? prod / 210 : prod / 182;
				8: term = want_sin ? prod / 272 : prod / 240;
				default: term = prod;
			endcase
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	// Q30 value scaled by the radius, rounded half away from zero to Q8.
	function automatic int to_q8(input longint v);
		longint unsigned mag;
		int              m;
		mag = (v < 0) ? longint'(-v) : longint'(v);
		m   = int'((mag * 64'(RADIUS) + (64'd1 << 21)) >> 22);
		return (v < 0) ? -m : m;
	endfunction

	function automatic int clamp_idx(input int v);
		int t;
		t = v;
		if (t < -RADIUS) t = -RADIUS;
		if (t > RADIUS) t = RADIUS;
		return t + RADIUS;
	endfunction

	function automatic tap_t tap_entry(input int n);
		int              q;
		int              r;
		longint unsigned theta;
		longint          s;
		longint          c;
		longint          sa;
		longint          ca;
		int              xq;
		int              yq;
		int              fx;
		int              fy;
		int              tx;
		int              ty;
		tap_t            t;
		q     = (4 * n) / NEIGHBORS;
		r     = 4 * n - q * NEIGHBORS;
		theta = HALF_PI_Q30 * 64'(r) / NEIGHBORS;
		s     = trig_q30(theta, 1'b1);
		c     = trig_q30(theta, 1'b0);
		case (q & 3)
			0:       begin sa = s;  ca = c;  end
			1:       begin sa = c;  ca = -s; end
			2:       begin sa = -s; ca = -c; end
			default: begin sa = -c; ca = s;  end
		endcase
		xq = -to_q8(sa);
		yq = to_q8(ca);
		fx = xq >>> 8;
		fy = yq >>> 8;
		tx = xq - fx * 256;
		ty = yq - fy * 256;
		t.col_lo = TAP_IDX_BITS'(clamp_idx(fx));
		t.col_hi = TAP_IDX_BITS'(clamp_idx((tx != 0) ? fx + 1 : fx));
		t.row_lo = TAP_IDX_BITS'(clamp_idx(fy));
		t.row_hi = TAP_IDX_BITS'(clamp_idx((ty != 0) ? fy + 1 : fy));
		t.wt[0]  = WEIGHT_BITS'((256 - tx) * (256 - ty));
		t.wt[1]  = WEIGHT_BITS'(tx * (256 - ty));
		t.wt[2]  = WEIGHT_BITS'((256 - tx) * ty);
		t.wt[3]  = WEIGHT_BITS'(tx * ty);
		return t;
	endfunction

	logic [PB-1:0] win_q [SPAN][SPAN];
	logic          valid_s2;
	beat_ctrl_t    ctrl_s2;
	logic          valid_s3_q;
	beat_ctrl_t    ctrl_s3_q;
	logic [PB-1:0] centre_s3;

	// Shift the window left and take the new column on the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SPAN; k++) begin
				for (int dx = 0; dx < SPAN; dx++) begin
					win_q[k][dx] <= '0;
				end
			end
		end else if (advance && valid_s1) begin
			for (int k = 0; k < SPAN; k++) begin
				for (int dx = 0; dx < SPAN - 1; dx++) begin
					win_q[k][dx] <= win_q[k][dx + 1];
				end
				win_q[k][SPAN-1] <= column[k*PB +: PB];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			valid_s3_q <= 1'b0;
		end else if (advance) begin
			valid_s2   <= valid_s1;
			valid_s3_q <= valid_s2 && ctrl_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ctrl_s2   <= ctrl_s1;
			ctrl_s3_q <= ctrl_s2;
			centre_s3 <= win_q[RADIUS][RADIUS];
		end
	end

	for (genvar n = 0; n < NEIGHBORS; n++) begin : g_tap
		localparam tap_t TAP = tap_entry(n);
		localparam int RL = int'(TAP.row_lo);
		localparam int RH = int'(TAP.row_hi);
		localparam int CL = int'(TAP.col_lo);
		localparam int CH = int'(TAP.col_hi);

		logic [PW-1:0]   prod_s3 [4];
		logic [PW+1:0]   sum;

		always_ff @(posedge clk) begin
			if (advance) begin
				prod_s3[0] <= PW'(win_q[RL][CL]) * PW'(TAP.wt[0]);
				prod_s3[1] <= PW'(win_q[RL][CH]) * PW'(TAP.wt[1]);
				prod_s3[2] <= PW'(win_q[RH][CL]) * PW'(TAP.wt[2]);
				prod_s3[3] <= PW'(win_q[RH][CH]) * PW'(TAP.wt[3]);
			end
		end

		assign sum = (PW + 2)'(prod_s3[0]) + (PW + 2)'(prod_s3[1])
		           + (PW + 2)'(prod_s3[2]) + (PW + 2)'(prod_s3[3]);
		assign code[n] = sum >= (PW + 2)'({centre_s3, 16'h0000});
	end

	assign valid_s3 = valid_s3_q;
	assign ctrl_s3  = ctrl_s3_q;

endmodule
